// File: hdl/oneshot_periodic_timer_table_macros.svh
// Assertion macros used by the timer table RTL.
`ifndef ONESHOT_PERIODIC_TIMER_TABLE_MACROS_SVH
`define ONESHOT_PERIODIC_TIMER_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define OPTT_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("timer table assertion failed");

// Next-cycle implication, disabled while reset is high.
`define OPTT_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("timer table assertion failed");

`endif

// File: hdl/optt_pkg.sv
// Package with constants and types of the one-shot and periodic timer table.
package optt_pkg;

   // Table size and field widths.
   localparam int SLOTS   = 16;
   localparam int SLOT_AW = $clog2(SLOTS);
   localparam int ID_W    = 5;
   localparam int TIME_W  = 32;
   localparam int SCALE_W = 16;

   // Opcodes of an input item.
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_SET   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // Result status codes.
   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_RANGE     = 3'd1,
      STATUS_NOT_FOUND = 3'd2,
      STATUS_MISMATCH  = 3'd3,
      STATUS_FULL      = 3'd4
   } status_type;

   // One slot entry as held in the slot memory.
   typedef struct packed {
      logic              oneshot;
      logic [TIME_W-1:0] window_start;
      logic [TIME_W-1:0] deadline;
      logic [TIME_W-1:0] period;
   } slot_type;

   // One result item.
   typedef struct packed {
      status_type      status;
      logic [ID_W-1:0] result_id;
      logic            fired;
      logic [ID_W-1:0] live_count;
      logic            last;
   } rsp_type;

endpackage

// File: hdl/oneshot_periodic_timer_table.sv
// Top level of the one-shot and periodic timer table.

// The block takes one command at a time: start is sampled while busy is low.
// A clear of id zero, of an id past the table, of a free slot, or an unknown
// opcode answers straight from idle; a checked clear first reads the slot and
// answers from the check state; a set runs the tick-to-millisecond multiply,
// the clock add and the slot write in that order. A tick runs the multiply and
// the add, then a walk of the 16 slots with one slot-memory read per cycle, a
// drain of the read pipeline and the final count result. Each result is shown
// for exactly one cycle with rsp_strobe high and cannot be held off, so the
// receiver must take every strobe; a tick gives at most one result per cycle.
// Slot records live in a one-port-read, one-port-write memory with registered
// read data; only the live bits sit in flip-flops, so there is no clearing
// pass after reset.

`include "oneshot_periodic_timer_table_macros.svh"

module oneshot_periodic_timer_table
   import optt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [TIME_W-1:0]  req_system_ticks,
   input  logic [TIME_W-1:0]  req_interval_ms,
   input  logic [ID_W-1:0]    req_timer_id,
   input  logic               req_one_shot,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_status,
   output logic [ID_W-1:0]    rsp_result_id,
   output logic               rsp_fired,
   output logic [ID_W-1:0]    rsp_live_count,
   output logic               rsp_last,
   input  logic               csr_we,
   input  logic [SCALE_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_SET,
      ST_CLR_CHK,
      ST_TICK_RUN,
      ST_TICK_DRAIN,
      ST_TICK_END
   } state_type;

   // Registers and their next values.
   state_type            state_ff, state_in;
   logic [SCALE_W-1:0]   time_scale_ff, time_scale_in;
   logic [TIME_W-1:0]    prev_ticks_ff, prev_ticks_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic [TIME_W-1:0]    prod_ff, prod_in;
   logic [SLOTS-1:0]     live_ff, live_in;
   logic [ID_W-1:0]      lowest_ff, lowest_in;
   logic                 is_set_ff, is_set_in;
   logic [TIME_W-1:0]    interval_ff, interval_in;
   logic                 oneshot_ff, oneshot_in;
   logic [SLOT_AW-1:0]   idx_ff, idx_in;
   logic                 eval_vld_ff, eval_vld_in;
   logic [SLOT_AW-1:0]   eval_idx_ff, eval_idx_in;
   logic [ID_W-1:0]      count_ff, count_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;

   // Slot memory ports.
   slot_type             slot_mem [SLOTS];
   logic                 mem_we;
   logic [SLOT_AW-1:0]   mem_waddr;
   slot_type             mem_wdata;
   logic [SLOT_AW-1:0]   mem_raddr;
   slot_type             mem_rdata_ff;

   // Derived values.
   logic [TIME_W-1:0]    tick_delta;
   logic [TIME_W+SCALE_W-1:0] prod_full;
   logic [ID_W-1:0]      tid_m1;
   logic [SLOT_AW-1:0]   tid_idx;
   logic [ID_W-1:0]      lowest_m1;
   logic [SLOT_AW-1:0]   set_idx;
   logic [ID_W-1:0]      eval_id;
   logic                 waiting;

   // Lowest free id above the given id, or one past the table when none is free.
   function automatic logic [ID_W-1:0] next_free(input logic [SLOTS-1:0] live,
                                                 input logic [ID_W-1:0]  id);
      logic [ID_W-1:0] result;
      result = ID_W'(SLOTS + 1);
      for (int j = SLOTS - 1; j >= 0; j--) begin
         if (j >= int'(id) && !live[j]) begin
            result = ID_W'(j + 1);
         end
      end
      return result;
   endfunction

   assign tick_delta = req_system_ticks - prev_ticks_ff;
   assign prod_full  = time_scale_ff * tick_delta;
   assign tid_m1     = req_timer_id - 1'b1;
   assign tid_idx    = tid_m1[SLOT_AW-1:0];
   assign lowest_m1  = lowest_ff - 1'b1;
   assign set_idx    = lowest_m1[SLOT_AW-1:0];
   assign eval_id    = ID_W'(eval_idx_ff) + 1'b1;

   // Wrap-aware window test of the slot under evaluation against the clock.
   always_comb begin
      if (mem_rdata_ff.window_start < mem_rdata_ff.deadline) begin
         waiting = (mem_rdata_ff.window_start <= now_ff) &&
                   (now_ff < mem_rdata_ff.deadline);
      end else begin
         waiting = (now_ff < mem_rdata_ff.deadline) ||
                   (mem_rdata_ff.window_start <= now_ff);
      end
   end

   // Next-state logic for the sequencer, the table state and the result register.
   always_comb begin
      state_in      = state_ff;
      time_scale_in = time_scale_ff;
      prev_ticks_in = prev_ticks_ff;
      now_in        = now_ff;
      prod_in       = prod_ff;
      live_in       = live_ff;
      lowest_in     = lowest_ff;
      is_set_in     = is_set_ff;
      interval_in   = interval_ff;
      oneshot_in    = oneshot_ff;
      idx_in        = idx_ff;
      eval_vld_in   = eval_vld_ff;
      eval_idx_in   = eval_idx_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '{STATUS_OK, '0, 1'b0, '0, 1'b1};
      mem_we        = 1'b0;
      mem_waddr     = eval_idx_ff;
      mem_wdata     = mem_rdata_ff;
      mem_raddr     = idx_ff;

      if (csr_we) begin
         time_scale_in = csr_wdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_opcode)
                  OP_TICK, OP_SET: begin
                     prev_ticks_in = req_system_ticks;
                     prod_in       = prod_full[TIME_W-1:0];
                     is_set_in     = (req_opcode == OP_SET);
                     interval_in   = req_interval_ms;
                     oneshot_in    = req_one_shot;
                     state_in      = ST_ADD;
                  end
                  OP_CLEAR: begin
                     if (req_timer_id == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = STATUS_RANGE;
                     end else if (req_timer_id > ID_W'(SLOTS) || !live_ff[tid_idx]) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = STATUS_NOT_FOUND;
                     end else begin
                        mem_raddr   = tid_idx;
                        eval_idx_in = tid_idx;
                        oneshot_in  = req_one_shot;
                        state_in    = ST_CLR_CHK;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_in.status = STATUS_RANGE;
                  end
               endcase
            end
         end
         ST_ADD: begin
            now_in = now_ff + prod_ff;
            if (is_set_ff) begin
               state_in = ST_SET;
            end else begin
               idx_in      = '0;
               count_in    = '0;
               eval_vld_in = 1'b0;
               state_in    = ST_TICK_RUN;
            end
         end
         ST_SET: begin
            rsp_strobe_in = 1'b1;
            if (lowest_ff > ID_W'(SLOTS)) begin
               rsp_in.status = STATUS_FULL;
            end else begin
               mem_we           = 1'b1;
               mem_waddr        = set_idx;
               mem_wdata        = '{oneshot_ff, now_ff, now_ff + interval_ff, interval_ff};
               live_in[set_idx] = 1'b1;
               lowest_in        = next_free(live_ff, lowest_ff);
               rsp_in.result_id = lowest_ff;
            end
            state_in = ST_IDLE;
         end
         ST_CLR_CHK: begin
            rsp_strobe_in = 1'b1;
            if (mem_rdata_ff.oneshot != oneshot_ff) begin
               rsp_in.status = STATUS_MISMATCH;
            end else begin
               live_in[eval_idx_ff] = 1'b0;
               if (eval_id < lowest_ff) begin
                  lowest_in = eval_id;
               end
            end
            state_in = ST_IDLE;
         end
         ST_TICK_RUN: begin
            mem_raddr   = idx_ff;
            eval_vld_in = 1'b1;
            eval_idx_in = idx_ff;
            idx_in      = idx_ff + 1'b1;
            if (idx_ff == SLOT_AW'(SLOTS - 1)) begin
               state_in = ST_TICK_DRAIN;
            end
         end
         ST_TICK_DRAIN: begin
            eval_vld_in = 1'b0;
            state_in    = ST_TICK_END;
         end
         ST_TICK_END: begin
            rsp_strobe_in     = 1'b1;
            rsp_in.live_count = count_ff;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Slot evaluation, in the cycle after the memory read of the walk.
      if (eval_vld_ff && live_ff[eval_idx_ff]) begin
         count_in = count_ff + 1'b1;
         if (!waiting) begin
            rsp_strobe_in    = 1'b1;
            rsp_in.result_id = eval_id;
            rsp_in.fired     = 1'b1;
            rsp_in.last      = 1'b0;
            if (mem_rdata_ff.oneshot) begin
               live_in[eval_idx_ff] = 1'b0;
               if (eval_id < lowest_ff) begin
                  lowest_in = eval_id;
               end
            end else begin
               mem_we    = 1'b1;
               mem_waddr = eval_idx_ff;
               mem_wdata = '{1'b0, mem_rdata_ff.deadline,
                             mem_rdata_ff.deadline + mem_rdata_ff.period,
                             mem_rdata_ff.period};
            end
         end
      end
   end

   // State, table control and registered result outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         time_scale_ff <= SCALE_W'(1);
         prev_ticks_ff <= '0;
         now_ff        <= '0;
         live_ff       <= '0;
         lowest_ff     <= ID_W'(1);
         eval_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         time_scale_ff <= time_scale_in;
         prev_ticks_ff <= prev_ticks_in;
         now_ff        <= now_in;
         live_ff       <= live_in;
         lowest_ff     <= lowest_in;
         eval_vld_ff   <= eval_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      prod_ff     <= prod_in;
      is_set_ff   <= is_set_in;
      interval_ff <= interval_in;
      oneshot_ff  <= oneshot_in;
      idx_ff      <= idx_in;
      eval_idx_ff <= eval_idx_in;
      count_ff    <= count_in;
      rsp_ff      <= rsp_in;
   end

   // Slot memory with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= slot_mem[mem_raddr];
   end

   // Port drive.
   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_result_id  = rsp_ff.result_id;
   assign rsp_fired      = rsp_ff.fired;
   assign rsp_live_count = rsp_ff.live_count;
   assign rsp_last       = rsp_ff.last;

   // A fired result is never the last one of a tick and names a real slot.
   `OPTT_ASSERT_IMPLIES(a_fired_not_last, clock, reset, rsp_strobe && rsp_fired, !rsp_last && rsp_result_id != '0)
   // A tick transfer always makes the block busy.
   `OPTT_ASSERT_NEXT(a_tick_goes_busy, clock, reset, start && !busy && req_opcode == OP_TICK, busy)
   // A result shown while idle closes its item.
   `OPTT_ASSERT_IMPLIES(a_idle_result_last, clock, reset, rsp_strobe && state_ff == ST_IDLE, rsp_last)
   // The lowest free id, when inside the table, points at a free slot.
   `OPTT_ASSERT_IMPLIES(a_lowest_is_free, clock, reset, lowest_ff <= ID_W'(SLOTS), !live_ff[set_idx])

endmodule
